[hdl/nlc_pkg.sv]
package nlc_pkg;

  localparam int ID_W   = 16;
  localparam int MASK_W = 16;
  localparam int IDX_W  = 4;
  localparam int DATA_W = ID_W + MASK_W;

  // Operation selector carried on the input tuser.
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // Result kind carried on the output tuser.
  localparam logic KIND_ITEM = 1'b0;
  localparam logic KIND_ID   = 1'b1;

  typedef struct packed {
    logic load;  // input word accepted this cycle
    logic emit;  // move the current result into the output register
  } nlc_cmd_t;

  typedef struct packed {
    logic load_busy; // the word being accepted produces at least one result
    logic cur_last;  // the current result is the last one of its input word
    logic out_free;  // the output register can take a result this cycle
  } nlc_sts_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [IDX_W-1:0] low_bit_idx(input logic [MASK_W-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hdl/nack_loss_list_codec.sv]
// Channel  Direction  tdata (low bit up)            tuser          tlast
// s_*      in         seq_id[15:0], loss_mask[31:16] opcode         list_end
// m_*      out        out_id[15:0], out_mask[31:16]  result_kind    run_last
//
// An encode word that only joins or opens an item is taken without a busy
// state; one that closes items emits one result per item closed (one or two).
// A decode word yields 1 + popcount(loss_mask) results, the base id and one per
// lost id, paced by the single output register that every result passes.
// s_tready is low while results of the accepted word are still being moved
// to the output register; a stalled m_tready holds that register and stalls
// the input in turn. Reset (rst, synchronous) closes any open item.
module nack_loss_list_codec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [nlc_pkg::DATA_W-1:0] s_tdata,  // seq_id, loss_mask
  input  logic                       s_tuser,  // opcode
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [nlc_pkg::DATA_W-1:0] m_tdata,  // out_id, out_mask
  output logic                       m_tuser,  // result_kind
  output logic                       m_tlast
);

  nlc_pkg::nlc_cmd_t cmd;
  nlc_pkg::nlc_sts_t sts;

  nlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

  // A decode word always yields results, so the input must close behind it.
  a_dec_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == nlc_pkg::OP_DEC) |=> !s_tready)
    else $error("decode word accepted without entering busy");

  // The end of an encode list always emits the open item.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == nlc_pkg::OP_ENC && s_tlast) |=> !s_tready)
    else $error("list end accepted without emitting an item");

  // Decoded ids carry an empty mask.
  a_id_mask: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == nlc_pkg::KIND_ID) |-> (m_tdata[31:16] == '0))
    else $error("decoded id with nonzero mask");

endmodule

[hdl/nlc_ctrl.sv]
module nlc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  nlc_pkg::nlc_sts_t sts,
  output nlc_pkg::nlc_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.load_busy) begin
            state_next = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.cur_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/nlc_dp.sv]
module nlc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [nlc_pkg::DATA_W-1:0]   s_tdata,
  input  logic                         s_tuser,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nlc_pkg::DATA_W-1:0]   m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast,
  input  nlc_pkg::nlc_cmd_t            cmd,
  output nlc_pkg::nlc_sts_t            sts
);

  logic [nlc_pkg::ID_W-1:0]   in_id;
  logic [nlc_pkg::MASK_W-1:0] in_mask;

  // Open encode item.
  logic                       item_open;
  logic [nlc_pkg::ID_W-1:0]   open_base;
  logic [nlc_pkg::MASK_W-1:0] open_mask;

  // Pending encode results, head in slot 0.
  logic [1:0]                 q_cnt;
  logic [nlc_pkg::ID_W-1:0]   q_id   [2];
  logic [nlc_pkg::MASK_W-1:0] q_mask [2];

  // Decode job.
  logic                       job_dec;
  logic                       dec_first;
  logic [nlc_pkg::ID_W-1:0]   dec_base;
  logic [nlc_pkg::MASK_W-1:0] dec_rem;

  // Encode step for the incoming id.
  logic [nlc_pkg::ID_W-1:0]   gap;
  logic                       join_item;
  logic                       emit_old;
  logic [nlc_pkg::ID_W-1:0]   base_n;
  logic [nlc_pkg::MASK_W-1:0] mask_n;
  logic [1:0]                 enc_cnt;
  logic                       is_enc;

  // Decode step.
  logic [nlc_pkg::IDX_W-1:0]  low_idx;
  logic [nlc_pkg::IDX_W:0]    dec_step;
  logic [nlc_pkg::ID_W-1:0]   dec_id;
  logic [nlc_pkg::MASK_W-1:0] dec_rem_n;

  // Current result.
  logic                       cur_kind;
  logic [nlc_pkg::ID_W-1:0]   cur_id;
  logic [nlc_pkg::MASK_W-1:0] cur_mask;
  logic                       cur_last;

  assign in_id   = s_tdata[nlc_pkg::ID_W-1:0];
  assign in_mask = s_tdata[nlc_pkg::DATA_W-1:nlc_pkg::ID_W];
  assign is_enc  = (s_tuser == nlc_pkg::OP_ENC);

  // The id joins the open item when it lies 1 to 16 past the base.
  assign gap       = in_id - open_base - nlc_pkg::ID_W'(1);
  assign join_item = item_open && (gap[nlc_pkg::ID_W-1:nlc_pkg::IDX_W] == '0);
  assign emit_old  = item_open && !join_item;

  always_comb begin
    if (join_item) begin
      base_n = open_base;
      mask_n = open_mask | (nlc_pkg::MASK_W'(1) << gap[nlc_pkg::IDX_W-1:0]);
    end else begin
      base_n = in_id;
      mask_n = '0;
    end
  end

  assign enc_cnt = {1'b0, emit_old} + {1'b0, s_tlast};

  assign low_idx   = nlc_pkg::low_bit_idx(dec_rem);
  assign dec_step  = {1'b0, low_idx} + (nlc_pkg::IDX_W+1)'(1);
  assign dec_id    = dec_base + {{(nlc_pkg::ID_W-nlc_pkg::IDX_W-1){1'b0}}, dec_step};
  assign dec_rem_n = dec_rem & (dec_rem - nlc_pkg::MASK_W'(1));

  always_comb begin
    if (job_dec) begin
      cur_kind = nlc_pkg::KIND_ID;
      cur_mask = '0;
      if (dec_first) begin
        cur_id   = dec_base;
        cur_last = (dec_rem == '0);
      end else begin
        cur_id   = dec_id;
        cur_last = (dec_rem_n == '0);
      end
    end else begin
      cur_kind = nlc_pkg::KIND_ITEM;
      cur_id   = q_id[0];
      cur_mask = q_mask[0];
      cur_last = (q_cnt == 2'd1);
    end
  end

  assign sts.load_busy = !is_enc || (enc_cnt != 2'd0);
  assign sts.cur_last  = cur_last;
  assign sts.out_free  = !m_tvalid || m_tready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_open <= 1'b0;
      q_cnt     <= 2'd0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load && is_enc) begin
        item_open <= !s_tlast;
        q_cnt     <= enc_cnt;
      end else if (cmd.emit && !job_dec) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

  // Payload and job registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      job_dec   <= !is_enc;
      dec_first <= 1'b1;
      dec_base  <= in_id;
      dec_rem   <= in_mask;
      if (is_enc) begin
        open_base <= base_n;
        open_mask <= mask_n;
        if (emit_old) begin
          q_id[0]   <= open_base;
          q_mask[0] <= open_mask;
          q_id[1]   <= base_n;
          q_mask[1] <= mask_n;
        end else begin
          q_id[0]   <= base_n;
          q_mask[0] <= mask_n;
        end
      end
    end else if (cmd.emit) begin
      if (job_dec) begin
        dec_first <= 1'b0;
        if (!dec_first) begin
          dec_rem <= dec_rem_n;
        end
      end else begin
        q_id[0]   <= q_id[1];
        q_mask[0] <= q_mask[1];
      end
    end
    if (cmd.emit) begin
      m_tuser <= cur_kind;
      m_tdata <= {cur_mask, cur_id};
      m_tlast <= cur_last;
    end
  end

endmodule

[tb/nack_loss_list_codec_tb.sv]
module nack_loss_list_codec_tb;

  localparam int MASK_TOP    = 15;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 240;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic                       op;
    logic [nlc_pkg::ID_W-1:0]   id;
    logic [nlc_pkg::MASK_W-1:0] mask;
    logic                       last;
    logic                       drain;  // hold this word back until all results are in
  } nack_word_t;

  typedef struct {
    logic                       kind;
    logic [nlc_pkg::ID_W-1:0]   id;
    logic [nlc_pkg::MASK_W-1:0] mask;
    logic                       last;
  } nack_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [nlc_pkg::DATA_W-1:0] s_tdata = '0;  // seq_id, loss_mask
  logic                       s_tuser = nlc_pkg::OP_ENC;  // opcode
  logic                       s_tlast = 1'b0;  // list_end
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [nlc_pkg::DATA_W-1:0] m_tdata;  // out_id, out_mask
  logic                       m_tuser;  // result_kind
  logic                       m_tlast;  // run_last

  nack_word_t   queued_words[$];
  nack_result_t due_results[$];

  // Encoder state as the block should hold it.
  logic                       enc_open = 1'b0;
  logic [nlc_pkg::ID_W-1:0]   enc_base = '0;
  logic [nlc_pkg::MASK_W-1:0] enc_mask = '0;

  int   words_accepted = 0;
  int   total_words = 0;
  int   mismatches = 0;
  int   stall_cycles = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic all_drained = 1'b1;

  nack_loss_list_codec dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_word(input logic op, input logic [nlc_pkg::ID_W-1:0] id,
                                   input logic [nlc_pkg::MASK_W-1:0] mask,
                                   input logic last);
    nack_word_t w;
    w.op    = op;
    w.id    = id;
    w.mask  = mask;
    w.last  = last;
    w.drain = 1'b0;
    queued_words.insert(queued_words.size(), w);
  endfunction

  // Both sides back off with a chance of 9 in 100, except in a quiet window mid-run.
  function automatic logic idle_roll();
    if (words_accepted >= 260 && words_accepted < 340) begin
      return 1'b0;
    end
    return $urandom_range(99) < 9;
  endfunction

  // Expected results of one accepted word, in order, appended to due_results.
  task automatic predict_codec(input nack_word_t w);
    nack_result_t               r[$];
    logic [nlc_pkg::ID_W-1:0]   gap;
    logic [nlc_pkg::ID_W-1:0]   lost_id;
    if (w.op == nlc_pkg::OP_ENC) begin
      gap = w.id - enc_base - 16'd1;
      if (enc_open && gap <= MASK_TOP) begin
        enc_mask = enc_mask | (16'd1 << gap);
      end else begin
        if (enc_open) begin
          r.insert(r.size(),
                   nack_result_t'{nlc_pkg::KIND_ITEM, enc_base, enc_mask, 1'b0});
        end
        enc_open = 1'b1;
        enc_base = w.id;
        enc_mask = '0;
      end
      if (w.last) begin
        r.insert(r.size(),
                 nack_result_t'{nlc_pkg::KIND_ITEM, enc_base, enc_mask, 1'b0});
        enc_open = 1'b0;
        enc_base = '0;
        enc_mask = '0;
      end
    end else begin
      r.insert(r.size(), nack_result_t'{nlc_pkg::KIND_ID, w.id, '0, 1'b0});
      for (int i = 0; i <= MASK_TOP; i++) begin
        if (w.mask[i]) begin
          lost_id = w.id + 16'(i + 1);
          r.insert(r.size(), nack_result_t'{nlc_pkg::KIND_ID, lost_id, '0, 1'b0});
        end
      end
    end
    if (r.size() > 0) begin
      r[r.size()-1].last = 1'b1;
    end
    foreach (r[k]) begin
      due_results.insert(due_results.size(), r[k]);
    end
  endtask

  always @(posedge clk) begin : drive_proc
    nack_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= nlc_pkg::OP_ENC;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        words_accepted <= words_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (queued_words.size() > 0 && !idle_roll() &&
            (!queued_words[0].drain || (!s_tvalid && all_drained))) begin
          w = queued_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {w.mask, w.id};
          s_tuser  <= w.op;
          s_tlast  <= w.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off starts once enough words went in, so the sender is busy.
  always @(posedge clk) begin : sink_proc
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && words_accepted >= 120) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= !idle_roll();
    end
  end

  always @(posedge clk) begin : check_proc
    nack_result_t want;
    nack_word_t   seen;
    if (rst) begin
      all_drained <= 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word kind=%b id=%h mask=%h last=%b", $time,
                   m_tuser, m_tdata[nlc_pkg::ID_W-1:0],
                   m_tdata[nlc_pkg::DATA_W-1:nlc_pkg::ID_W], m_tlast);
          mismatches <= mismatches + 1;
        end else begin
          want = due_results.pop_front();
          if (m_tuser !== want.kind || m_tdata[nlc_pkg::ID_W-1:0] !== want.id ||
              m_tdata[nlc_pkg::DATA_W-1:nlc_pkg::ID_W] !== want.mask ||
              m_tlast !== want.last) begin
            $display("%0t: expected kind=%b id=%h mask=%h last=%b, got kind=%b id=%h mask=%h last=%b",
                     $time, want.kind, want.id, want.mask, want.last, m_tuser,
                     m_tdata[nlc_pkg::ID_W-1:0],
                     m_tdata[nlc_pkg::DATA_W-1:nlc_pkg::ID_W], m_tlast);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen.op    = s_tuser;
        seen.id    = s_tdata[nlc_pkg::ID_W-1:0];
        seen.mask  = s_tdata[nlc_pkg::DATA_W-1:nlc_pkg::ID_W];
        seen.last  = s_tlast;
        seen.drain = 1'b0;
        predict_codec(seen);
      end
      all_drained <= (due_results.size() == 0);
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stim_proc
    logic [nlc_pkg::ID_W-1:0] id;
    int                       pick;
    int                       run_len;
    int                       directed_count;

    // Window edges, wraparound, repeats and a decode while an item is open.
    add_word(nlc_pkg::OP_ENC, 16'h0000, 16'hFFFF, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0001, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0010, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0010, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0011, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0011, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'hFFF0, 16'h0000, 1'b1);
    add_word(nlc_pkg::OP_ENC, 16'hFFFF, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h000F, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'h0000, 16'h0000, 1'b1);
    add_word(nlc_pkg::OP_ENC, 16'h1234, 16'hFFFF, 1'b1);
    add_word(nlc_pkg::OP_ENC, 16'hABCD, 16'h0000, 1'b0);
    add_word(nlc_pkg::OP_DEC, 16'h8000, 16'h0000, 1'b1);
    add_word(nlc_pkg::OP_DEC, 16'hFFFF, 16'hFFFF, 1'b0);
    add_word(nlc_pkg::OP_DEC, 16'h0000, 16'h8001, 1'b0);
    add_word(nlc_pkg::OP_ENC, 16'hABCE, 16'h0000, 1'b1);
    add_word(nlc_pkg::OP_DEC, 16'h5555, 16'hAAAA, 1'b1);
    add_word(nlc_pkg::OP_ENC, 16'hFFFF, 16'h5555, 1'b1);
    directed_count = queued_words.size();

    // Well-formed loss lists in half the picks, mixed with decodes and stray encode words.
    while (queued_words.size() < directed_count + 410) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        id = (pick == 0) ? 16'($urandom_range(16'hFFFF, 16'hFFE8)) : 16'($urandom);
        run_len = $urandom_range(12, 1);
        for (int k = 0; k < run_len; k++) begin
          add_word(nlc_pkg::OP_ENC, id, 16'($urandom), k == run_len - 1);
          id = id + 16'($urandom_range(18, 0));
        end
      end else if (pick < 8) begin
        add_word(nlc_pkg::OP_DEC, 16'($urandom),
                 (pick == 5) ? 16'($urandom) : 16'($urandom) & 16'($urandom),
                 1'($urandom));
      end else begin
        add_word(nlc_pkg::OP_ENC, 16'($urandom), 16'($urandom),
                 $urandom_range(3) == 0);
      end
    end
    queued_words[directed_count].drain = 1'b1;
    queued_words[directed_count + 180].drain = 1'b1;
    total_words = queued_words.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!(words_accepted == total_words && all_drained && !s_tvalid)) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
